### hw/rtl/dilp_pkg.sv
// shared constants, codes, types and helpers for the decimal id list parser
package dilp_pkg;

    localparam int MAX_ENTRIES = 256;

    localparam int CHAR_W   = 8;
    localparam int CAP_W    = 9;
    localparam int ENTRY_W  = 9;
    localparam int IDX_W    = 8;
    localparam int VAL_W    = 16;
    localparam int ACC_W    = VAL_W + 1;
    localparam int PROD_W   = ACC_W + 4;
    localparam int DIGIT_W  = 4;
    localparam int STATUS_W = 3;
    localparam int PHASE_W  = 3;

    localparam int CFG_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // register indexes
    localparam logic [0:0] REG_CAPACITY = 1'b0;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(256);
    localparam logic [CAP_W-1:0] CAP_LIMIT = CAP_W'(MAX_ENTRIES);
    localparam logic [ACC_W-1:0] ACC_SAT   = ACC_W'(65536);

    // parser phases
    localparam logic [PHASE_W-1:0] PH_FIRST       = 3'd0;
    localparam logic [PHASE_W-1:0] PH_AFTER_COMMA = 3'd1;
    localparam logic [PHASE_W-1:0] PH_SIGN        = 3'd2;
    localparam logic [PHASE_W-1:0] PH_DIGITS      = 3'd3;
    localparam logic [PHASE_W-1:0] PH_AFTER_ID    = 3'd4;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_TOO_MANY = 3'd1;
    localparam logic [STATUS_W-1:0] ST_INVALID  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NO_COMMA = 3'd3;
    localparam logic [STATUS_W-1:0] ST_TRAILING = 3'd4;

    // character codes
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_COMMA = 8'h2C;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

    typedef struct packed {
        logic [CHAR_W-1:0] char_code;
        logic              char_present;
        logic              end_of_text;
    } t_in_item;

    typedef struct packed {
        logic                id_valid;
        logic [VAL_W-1:0]    id_value;
        logic [IDX_W-1:0]    id_index;
        logic                done_res;
        logic [STATUS_W-1:0] status;
        logic [ENTRY_W-1:0]  entry_count;
    } t_result;

    function automatic logic is_ws(input logic [CHAR_W-1:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    function automatic logic is_digit(input logic [CHAR_W-1:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

endpackage

### hw/rtl/dilp_in_if.sv
// input byte channel: valid/ready handshake with one text byte and its flags
interface dilp_in_if;
    logic                          valid;
    logic                          ready;
    logic [dilp_pkg::CHAR_W-1:0]   char_code;
    logic                          char_present;
    logic                          end_of_text;

    modport source (output valid, output char_code, output char_present,
                    output end_of_text, input ready);
    modport sink   (input valid, input char_code, input char_present,
                    input end_of_text, output ready);
endinterface

### hw/rtl/dilp_out_if.sv
// result channel: valid/ready handshake with id, done flag, status and count
interface dilp_out_if;
    logic                          valid;
    logic                          ready;
    logic                          id_valid;
    logic [dilp_pkg::VAL_W-1:0]    id_value;
    logic [dilp_pkg::IDX_W-1:0]    id_index;
    logic                          done_res;
    logic [dilp_pkg::STATUS_W-1:0] status;
    logic [dilp_pkg::ENTRY_W-1:0]  entry_count;

    modport source (output valid, output id_valid, output id_value, output id_index,
                    output done_res, output status, output entry_count, input ready);
    modport sink   (input valid, input id_valid, input id_value, input id_index,
                    input done_res, input status, input entry_count, output ready);
endinterface

### hw/rtl/dilp_apb_regs.sv
// apb configuration register file holding the capacity register
module dilp_apb_regs (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [dilp_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [dilp_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [dilp_pkg::APB_DATA_W-1:0]    prdata,
    output logic                               pready,
    output logic [dilp_pkg::CAP_W-1:0]         o_capacity
);

    logic                         capacity_we;
    logic [dilp_pkg::CAP_W-1:0]   r_capacity;
    logic                         sel_capacity;

    assign sel_capacity = (paddr[dilp_pkg::CFG_ADDR_W-1:2] == dilp_pkg::REG_CAPACITY);
    assign capacity_we  = psel && penable && pwrite && sel_capacity;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= dilp_pkg::CAP_RESET;
        end else if (capacity_we) begin
            r_capacity <= pwdata[dilp_pkg::CAP_W-1:0];
        end
    end

    assign pready     = 1'b1;
    assign prdata     = sel_capacity
                        ? dilp_pkg::APB_DATA_W'(r_capacity)
                        : '0;
    assign o_capacity = r_capacity;

endmodule

### hw/rtl/dilp_parse.sv
// parser state registers and the per-byte next-state and result logic
module dilp_parse (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_fire,
    input  dilp_pkg::t_in_item            i_item,
    input  logic [dilp_pkg::CAP_W-1:0]    i_capacity,
    output dilp_pkg::t_result             o_result
);

    logic [dilp_pkg::PHASE_W-1:0]  r_phase,  n_phase;
    logic [dilp_pkg::ACC_W-1:0]    r_acc,    n_acc;
    logic                          r_minus,  n_minus;
    logic                          r_nz,     n_nz;
    logic [dilp_pkg::ENTRY_W-1:0]  r_count,  n_count;
    logic [dilp_pkg::STATUS_W-1:0] r_err,    n_err;

    logic [dilp_pkg::CAP_W-1:0]    lim;
    logic [dilp_pkg::DIGIT_W-1:0]  digit;
    logic [dilp_pkg::PROD_W-1:0]   prod;
    logic                          ch_ws;
    logic                          ch_dig;
    logic                          ch_comma;
    logic                          ch_plus;
    logic                          ch_minus;
    dilp_pkg::t_result             res;

    assign lim      = (i_capacity > dilp_pkg::CAP_LIMIT) ? dilp_pkg::CAP_LIMIT : i_capacity;
    assign digit    = i_item.char_code[dilp_pkg::DIGIT_W-1:0];
    assign ch_ws    = dilp_pkg::is_ws(i_item.char_code);
    assign ch_dig   = dilp_pkg::is_digit(i_item.char_code);
    assign ch_comma = (i_item.char_code == dilp_pkg::CH_COMMA);
    assign ch_plus  = (i_item.char_code == dilp_pkg::CH_PLUS);
    assign ch_minus = (i_item.char_code == dilp_pkg::CH_MINUS);

    // acc * 10 + digit as two shifted adds
    assign prod = dilp_pkg::PROD_W'({r_acc, 3'b000})
                + dilp_pkg::PROD_W'({r_acc, 1'b0})
                + dilp_pkg::PROD_W'(digit);

    always_comb begin
        n_phase = r_phase;
        n_acc   = r_acc;
        n_minus = r_minus;
        n_nz    = r_nz;
        n_count = r_count;
        n_err   = r_err;
        res     = '0;

        if (i_item.char_present && (r_err == dilp_pkg::ST_OK)) begin
            unique case (r_phase)
                dilp_pkg::PH_FIRST, dilp_pkg::PH_AFTER_COMMA: begin
                    if (!ch_ws) begin
                        // entry limit is checked before looking at the token
                        if (r_count >= lim) begin
                            n_err = dilp_pkg::ST_TOO_MANY;
                        end else begin
                            n_acc   = '0;
                            n_minus = 1'b0;
                            n_nz    = 1'b0;
                            if (ch_plus || ch_minus) begin
                                n_minus = ch_minus;
                                n_phase = dilp_pkg::PH_SIGN;
                            end else if (ch_dig) begin
                                n_acc   = dilp_pkg::ACC_W'(digit);
                                n_nz    = (digit != '0);
                                n_phase = dilp_pkg::PH_DIGITS;
                            end else begin
                                n_err = dilp_pkg::ST_INVALID;
                            end
                        end
                    end
                end
                dilp_pkg::PH_SIGN: begin
                    if (ch_dig) begin
                        n_acc   = dilp_pkg::ACC_W'(digit);
                        n_nz    = (digit != '0);
                        n_phase = dilp_pkg::PH_DIGITS;
                    end else begin
                        n_err = dilp_pkg::ST_INVALID;
                    end
                end
                dilp_pkg::PH_DIGITS: begin
                    if (ch_dig) begin
                        if (digit != '0) begin
                            n_nz = 1'b1;
                        end
                        // saturate at 65536, stop growing once there
                        if (!r_acc[dilp_pkg::ACC_W-1]) begin
                            if (prod > dilp_pkg::PROD_W'(dilp_pkg::ACC_SAT)) begin
                                n_acc = dilp_pkg::ACC_SAT;
                            end else begin
                                n_acc = prod[dilp_pkg::ACC_W-1:0];
                            end
                        end
                    end else if (r_acc[dilp_pkg::ACC_W-1] || (r_minus && r_nz)) begin
                        n_err = dilp_pkg::ST_INVALID;
                    end else begin
                        res.id_valid = 1'b1;
                        res.id_value = r_acc[dilp_pkg::VAL_W-1:0];
                        res.id_index = r_count[dilp_pkg::IDX_W-1:0];
                        n_count      = r_count + dilp_pkg::ENTRY_W'(1);
                        if (ch_ws) begin
                            n_phase = dilp_pkg::PH_AFTER_ID;
                        end else if (ch_comma) begin
                            n_phase = dilp_pkg::PH_AFTER_COMMA;
                        end else begin
                            n_phase = dilp_pkg::PH_AFTER_ID;
                            n_err   = dilp_pkg::ST_NO_COMMA;
                        end
                    end
                end
                default: begin
                    if (ch_comma) begin
                        n_phase = dilp_pkg::PH_AFTER_COMMA;
                    end else if (!ch_ws) begin
                        n_err = dilp_pkg::ST_NO_COMMA;
                    end
                end
            endcase
        end

        // end of text closes whatever token is open
        if (i_item.end_of_text && (n_err == dilp_pkg::ST_OK)) begin
            if (n_phase == dilp_pkg::PH_AFTER_COMMA) begin
                n_err = dilp_pkg::ST_TRAILING;
            end else if (n_phase == dilp_pkg::PH_SIGN) begin
                n_err = dilp_pkg::ST_INVALID;
            end else if (n_phase == dilp_pkg::PH_DIGITS) begin
                if (n_acc[dilp_pkg::ACC_W-1] || (n_minus && n_nz)) begin
                    n_err = dilp_pkg::ST_INVALID;
                end else begin
                    res.id_valid = 1'b1;
                    res.id_value = n_acc[dilp_pkg::VAL_W-1:0];
                    res.id_index = n_count[dilp_pkg::IDX_W-1:0];
                    n_count      = n_count + dilp_pkg::ENTRY_W'(1);
                    n_phase      = dilp_pkg::PH_AFTER_ID;
                end
            end
        end

        res.done_res    = i_item.end_of_text;
        res.status      = n_err;
        res.entry_count = n_count;

        // next text starts from scratch
        if (i_item.end_of_text) begin
            n_phase = dilp_pkg::PH_FIRST;
            n_acc   = '0;
            n_minus = 1'b0;
            n_nz    = 1'b0;
            n_count = '0;
            n_err   = dilp_pkg::ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= dilp_pkg::PH_FIRST;
            r_acc   <= '0;
            r_minus <= 1'b0;
            r_nz    <= 1'b0;
            r_count <= '0;
            r_err   <= dilp_pkg::ST_OK;
        end else if (i_fire) begin
            r_phase <= n_phase;
            r_acc   <= n_acc;
            r_minus <= n_minus;
            r_nz    <= n_nz;
            r_count <= n_count;
            r_err   <= n_err;
        end
    end

    assign o_result = res;

    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= dilp_pkg::ENTRY_W'(dilp_pkg::MAX_ENTRIES))
        else $error("entry count above the entry limit");

    a_done_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && i_item.end_of_text |=>
            (r_phase == dilp_pkg::PH_FIRST) && (r_err == dilp_pkg::ST_OK) && (r_count == '0))
        else $error("parser not cleared after end of text");

    a_error_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && (r_err != dilp_pkg::ST_OK) && !i_item.end_of_text |=>
            (r_err == $past(r_err)) && $stable(r_count))
        else $error("latched error changed or count moved after an error");

    a_id_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && o_result.id_valid && !i_item.end_of_text |=>
            r_count == $past(r_count) + dilp_pkg::ENTRY_W'(1))
        else $error("delivered id did not advance the entry count");

endmodule

### hw/rtl/decimal_id_list_parser.sv
// top level: input register, parser step, result register and config port
// an accepted byte is held in the input register, then its parser step result in the result register
// throughput: one byte per cycle while the result register is free or being drained
// while a result waits at the output the input register still takes one byte
// reset (i_rst_n low, synchronous) empties both registers, clears the parser state
// and sets capacity to 256
module decimal_id_list_parser (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    dilp_in_if.sink                            i_in,
    dilp_out_if.source                         o_out,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [dilp_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [dilp_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [dilp_pkg::APB_DATA_W-1:0]    prdata,
    output logic                               pready
);

    logic                          r_in_valid;
    dilp_pkg::t_in_item            r_in_item;
    logic                          r_out_valid;
    dilp_pkg::t_result             r_out_result;

    logic                          adv;
    logic                          in_ready;
    dilp_pkg::t_result             step_result;
    logic [dilp_pkg::CAP_W-1:0]    capacity;

    dilp_apb_regs u_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .o_capacity (capacity)
    );

    // step the parser when the result register is free or being drained
    assign adv      = r_in_valid && (!r_out_valid || o_out.ready);
    assign in_ready = !r_in_valid || adv;
    assign i_in.ready = in_ready;

    dilp_parse u_parse (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (adv),
        .i_item     (r_in_item),
        .i_capacity (capacity),
        .o_result   (step_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_ready) begin
                r_in_valid <= i_in.valid;
            end
            if (adv) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && in_ready) begin
            r_in_item.char_code    <= i_in.char_code;
            r_in_item.char_present <= i_in.char_present;
            r_in_item.end_of_text  <= i_in.end_of_text;
        end
        if (adv) begin
            r_out_result <= step_result;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.id_valid    = r_out_result.id_valid;
    assign o_out.id_value    = r_out_result.id_value;
    assign o_out.id_index    = r_out_result.id_index;
    assign o_out.done_res    = r_out_result.done_res;
    assign o_out.status      = r_out_result.status;
    assign o_out.entry_count = r_out_result.entry_count;

endmodule
